[rtl/escaped_frame_decoder_macros.svh]
// assertion helpers used by the checker file
`ifndef ESCAPED_FRAME_DECODER_MACROS_SVH
`define ESCAPED_FRAME_DECODER_MACROS_SVH

// clocked assertion, disabled while reset is held
`define EFD_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// implication checked on the following clock edge
`define EFD_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

[rtl/efd_pkg.sv]
package efd_pkg;

    localparam logic [7:0] BYTE_START     = 8'h7F;
    localparam logic [7:0] BYTE_END       = 8'h7E;
    localparam logic [7:0] BYTE_ESC       = 8'h7D;
    localparam logic [7:0] ESC_CODE_START = 8'h02;
    localparam logic [7:0] ESC_CODE_END   = 8'h01;
    localparam logic [7:0] ESC_CODE_ESC   = 8'h00;

    localparam logic [15:0] MAX_LEN_RESET = 16'd256;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_DATA = 2'd1,
        PH_ESC  = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_DATA  = 2'd1,
        CMD_END   = 2'd2
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind  kind;
        logic [7:0] data;
    } t_cmd;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_end;
        logic        first_of_frame;
        logic [15:0] frame_len;
        logic        overflowed;
    } t_result;

endpackage

[rtl/efd_front.sv]
module efd_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_byte,
    input  logic          i_space,
    output logic          o_ready,
    output logic          o_push,
    output efd_pkg::t_cmd o_cmd
);

    efd_pkg::t_phase r_phase;
    efd_pkg::t_phase n_phase;
    logic            w_take;

    assign o_ready = i_space;
    assign w_take  = i_valid && i_space;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= efd_pkg::PH_WAIT;
        end else begin
            r_phase <= n_phase;
        end
    end

    // next state
    always_comb begin
        n_phase = r_phase;
        if (w_take) begin
            case (r_phase)
                efd_pkg::PH_DATA: begin
                    if (i_byte == efd_pkg::BYTE_END) begin
                        n_phase = efd_pkg::PH_WAIT;
                    end else if (i_byte == efd_pkg::BYTE_ESC) begin
                        n_phase = efd_pkg::PH_ESC;
                    end
                end
                efd_pkg::PH_ESC: begin
                    n_phase = efd_pkg::PH_DATA;
                end
                default: begin
                    if (i_byte == efd_pkg::BYTE_START) begin
                        n_phase = efd_pkg::PH_DATA;
                    end else begin
                        n_phase = efd_pkg::PH_WAIT;
                    end
                end
            endcase
        end
    end

    // command classification
    always_comb begin
        o_push      = 1'b0;
        o_cmd.kind  = efd_pkg::CMD_DATA;
        o_cmd.data  = i_byte;
        case (r_phase)
            efd_pkg::PH_DATA: begin
                if (i_byte == efd_pkg::BYTE_END) begin
                    o_push     = w_take;
                    o_cmd.kind = efd_pkg::CMD_END;
                end else if (i_byte != efd_pkg::BYTE_ESC) begin
                    o_push     = w_take;
                end
            end
            efd_pkg::PH_ESC: begin
                o_push = w_take;
                if (i_byte == efd_pkg::ESC_CODE_END) begin
                    o_cmd.data = efd_pkg::BYTE_END;
                end else if (i_byte == efd_pkg::ESC_CODE_ESC) begin
                    o_cmd.data = efd_pkg::BYTE_ESC;
                end else if (i_byte == efd_pkg::ESC_CODE_START) begin
                    o_cmd.data = efd_pkg::BYTE_START;
                end
            end
            default: begin
                if (i_byte == efd_pkg::BYTE_START) begin
                    o_push     = w_take;
                    o_cmd.kind = efd_pkg::CMD_START;
                end
            end
        endcase
    end

endmodule

[rtl/efd_queue.sv]
module efd_queue #(
    parameter int DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  efd_pkg::t_cmd i_cmd,
    output logic          o_space,
    output logic          o_valid,
    input  logic          i_pop,
    output efd_pkg::t_cmd o_cmd
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    efd_pkg::t_cmd r_mem [DEPTH];
    logic [AW-1:0] r_wr_ptr;
    logic [AW-1:0] r_rd_ptr;
    logic [CW-1:0] r_count;
    logic [AW-1:0] n_wr_ptr;
    logic [AW-1:0] n_rd_ptr;
    logic [CW-1:0] n_count;
    logic          w_push;
    logic          w_pop;

    assign o_space = (r_count != CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd_ptr];
    assign w_push  = i_push && o_space;
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_pop && !w_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

endmodule

[rtl/efd_back.sv]
module efd_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wen,
    input  logic [15:0]      i_cfg_wdata,
    input  logic             i_valid,
    input  efd_pkg::t_cmd    i_cmd,
    output logic             o_pop,
    output logic             o_valid,
    input  logic             i_ready,
    output efd_pkg::t_result o_result
);

    logic [15:0]      r_max_len;
    logic [15:0]      r_kept;
    logic             r_first;
    logic             r_dropped;
    logic             r_out_valid;
    efd_pkg::t_result r_out;

    logic [15:0]      n_kept;
    logic             n_first;
    logic             n_dropped;
    logic             n_out_valid;
    efd_pkg::t_result n_out;
    logic             w_take;
    logic             w_emit;

    // the output register frees up in the same cycle it is taken
    assign w_take   = i_valid && (!r_out_valid || i_ready);
    assign o_pop    = w_take;
    assign o_valid  = r_out_valid;
    assign o_result = r_out;

    always_comb begin
        n_kept    = r_kept;
        n_first   = r_first;
        n_dropped = r_dropped;
        w_emit    = 1'b0;
        n_out     = r_out;
        if (w_take) begin
            case (i_cmd.kind)
                efd_pkg::CMD_START: begin
                    n_kept    = '0;
                    n_first   = 1'b1;
                    n_dropped = 1'b0;
                end
                efd_pkg::CMD_END: begin
                    w_emit               = 1'b1;
                    n_out.out_byte       = '0;
                    n_out.is_end         = 1'b1;
                    n_out.first_of_frame = r_first;
                    n_out.frame_len      = r_kept;
                    n_out.overflowed     = r_dropped;
                    n_kept               = '0;
                    n_first              = 1'b0;
                    n_dropped            = 1'b0;
                end
                default: begin
                    if (r_kept >= r_max_len) begin
                        n_dropped = 1'b1;
                    end else begin
                        w_emit               = 1'b1;
                        n_out.out_byte       = i_cmd.data;
                        n_out.is_end         = 1'b0;
                        n_out.first_of_frame = r_first;
                        n_out.frame_len      = '0;
                        n_out.overflowed     = 1'b0;
                        n_kept               = r_kept + 16'd1;
                        n_first              = 1'b0;
                    end
                end
            endcase
        end
        if (w_emit) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len   <= efd_pkg::MAX_LEN_RESET;
            r_kept      <= '0;
            r_first     <= 1'b0;
            r_dropped   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_wen) begin
                r_max_len <= i_cfg_wdata;
            end
            r_kept      <= n_kept;
            r_first     <= n_first;
            r_dropped   <= n_dropped;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out <= n_out;
        end
    end

endmodule

[rtl/escaped_frame_decoder.sv]
// Removes byte-stuffed framing from a raw link byte stream at one byte per clock cycle,
// sustained while the output is not stalled. A front stage tracks the start/escape/end
// framing and turns each byte into a start, data or end command; a small command queue
// (QUEUE_DEPTH entries) separates it from a back stage that counts kept bytes against the
// capacity register and drives a registered output. An accepted byte is registered in the
// queue and then in the output register; the rate is set by the single-entry-per-cycle
// queue and the output register, which is reloaded in the cycle its transaction completes.
// Data beats carry the decoded byte with tuser[0] marking the first result of a frame; an
// end marker has tlast set and carries the kept length, with tuser[1] flagging bytes
// dropped beyond max_frame_len. Write the capacity register only while the block is idle.
module escaped_frame_decoder #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wen,
    input  logic [15:0] i_cfg_wdata,    // max_frame_len
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // out_byte [7:0], frame_len [23:8]
    output logic        m_axis_tlast,   // is_end
    output logic [1:0]  m_axis_tuser    // first_of_frame [0], overflowed [1]
);

    logic             w_push;
    logic             w_space;
    logic             w_q_valid;
    logic             w_pop;
    efd_pkg::t_cmd    w_cmd_in;
    efd_pkg::t_cmd    w_cmd_out;
    efd_pkg::t_result w_result;

    efd_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_byte  (s_axis_tdata),
        .i_space (w_space),
        .o_ready (s_axis_tready),
        .o_push  (w_push),
        .o_cmd   (w_cmd_in)
    );

    efd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_cmd_in),
        .o_space (w_space),
        .o_valid (w_q_valid),
        .i_pop   (w_pop),
        .o_cmd   (w_cmd_out)
    );

    efd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_valid     (w_q_valid),
        .i_cmd       (w_cmd_out),
        .o_pop       (w_pop),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_result    (w_result)
    );

    assign m_axis_tdata = {w_result.frame_len, w_result.out_byte};
    assign m_axis_tlast = w_result.is_end;
    assign m_axis_tuser = {w_result.overflowed, w_result.first_of_frame};

endmodule

[rtl/efd_checker.sv]
`include "escaped_frame_decoder_macros.svh"

module efd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_cfg_wen,
    input logic [15:0] i_cfg_wdata,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [7:0]  s_axis_tdata,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [23:0] m_axis_tdata,
    input logic        m_axis_tlast,
    input logic [1:0]  m_axis_tuser
);

    // data beats never carry length or overflow
    `EFD_ASSERT(a_data_no_len, (m_axis_tvalid && !m_axis_tlast) |-> (m_axis_tdata[23:8] == 16'd0 && !m_axis_tuser[1]), "data beat carries end fields")

    // end marker carries a zero byte
    `EFD_ASSERT(a_end_zero_byte, (m_axis_tvalid && m_axis_tlast) |-> (m_axis_tdata[7:0] == 8'd0), "end marker byte not zero")

    // a stalled result stays put
    `EFD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser), "stalled output changed")

endmodule

bind escaped_frame_decoder efd_checker u_efd_checker (.*);
